[design/tcpq_pkg.sv]
// Shared types, constants and ring helpers for the two-class priority queue.
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_W       = 24;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t             THRESH_RESET = val_t'(15360);
    localparam cnt_t             DEPTH_CNT    = cnt_t'(QUEUE_DEPTH);
    localparam idx_t             LAST_IDX     = idx_t'(QUEUE_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_WIDE   = (IDX_W + 1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Both operands are below the depth, so one subtract brings the sum back into the ring.
    function automatic idx_t ring_add(idx_t base, idx_t off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_WIDE)
        begin
            sum = sum - DEPTH_WIDE;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t ring_dec(idx_t base);
        idx_t res;
        if (base == '0)
        begin
            res = LAST_IDX;
        end
        else
        begin
            res = base - idx_t'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[design/tcpq_if.sv]
// Request and response channel interfaces of the two-class priority queue.
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic signed [23:0]       data_value;

    modport source (output valid, output opcode, output data_value, input ready);
    modport sink   (input valid, input opcode, input data_value, output ready);
endinterface

interface tcpq_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [23:0]       removed_value;
    logic [4:0]               entry_count;

    modport source (output valid, output ok, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input ok, input removed_value, input entry_count,
                    output ready);
endinterface

`default_nettype wire

[design/tcpq_ram.sv]
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/two_class_priority_queue.sv]
// Two-class priority queue: ring of Q15.8 entries in a memory, head and count in registers.
// Insert and failed ops go from ST_IDLE to ST_DONE, remove passes through ST_READ, and search
// stays in ST_SEARCH while the walk reads one ring entry per cycle until a match or the window end.
// One request is in flight at a time; the next is taken after the result enters the output
// register. Asynchronous active-low reset empties the queue, sets the head to zero and the
// threshold to 60.0; the entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic signed [23:0]    cfg_wdata,
    tcpq_req_if.sink                   req,
    tcpq_rsp_if.source                 rsp
);

    tcpq_pkg::state_t  state_reg;
    tcpq_pkg::state_t  state_next;
    tcpq_pkg::idx_t    head_reg;
    tcpq_pkg::idx_t    head_next;
    tcpq_pkg::cnt_t    count_reg;
    tcpq_pkg::cnt_t    count_next;
    tcpq_pkg::val_t    thr_reg;
    tcpq_pkg::val_t    key_reg;
    tcpq_pkg::cnt_t    walk_reg;
    logic              pend_ok_reg;
    tcpq_pkg::val_t    pend_removed_reg;
    logic              rsp_valid_reg;
    logic              rsp_ok_reg;
    tcpq_pkg::val_t    rsp_removed_reg;
    tcpq_pkg::cnt_t    rsp_count_reg;

    tcpq_pkg::opcode_t op;
    logic              req_fire;
    logic              rsp_free;
    logic              is_empty;
    logic              is_full;
    logic              match;
    logic              search_done;

    logic              ram_we;
    tcpq_pkg::idx_t    ram_waddr;
    logic              ram_re;
    tcpq_pkg::idx_t    ram_raddr;
    logic [tcpq_pkg::VAL_W-1:0] ram_rdata;
    logic              req_ready;

    assign op          = tcpq_pkg::opcode_t'(req.opcode);
    assign req_fire    = req.valid && req_ready;
    assign rsp_free    = !rsp_valid_reg || rsp.ready;
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == tcpq_pkg::DEPTH_CNT);
    assign match       = (tcpq_pkg::val_t'(ram_rdata) == key_reg);
    assign search_done = match || (walk_reg == count_reg);

    tcpq_ram #(
        .WIDTH (tcpq_pkg::VAL_W),
        .DEPTH (tcpq_pkg::QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.data_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcpq_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if ((op == tcpq_pkg::OP_REMOVE) && !is_empty)
                    begin
                        state_next = tcpq_pkg::ST_READ;
                    end
                    else if ((op == tcpq_pkg::OP_SEARCH) && !is_empty)
                    begin
                        state_next = tcpq_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = tcpq_pkg::ST_DONE;
                    end
                end
            end
            tcpq_pkg::ST_READ:
            begin
                state_next = tcpq_pkg::ST_DONE;
            end
            tcpq_pkg::ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = tcpq_pkg::ST_DONE;
                end
            end
            tcpq_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = tcpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcpq_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory accesses and request ready.
    always_comb
    begin
        req_ready = (state_reg == tcpq_pkg::ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_re    = 1'b0;
        ram_raddr = head_reg;
        case (state_reg)
            tcpq_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (op)
                        tcpq_pkg::OP_INSERT:
                        begin
                            ram_we = !is_full;
                            if (is_empty)
                            begin
                                ram_waddr = head_reg;
                            end
                            else if (req.data_value > thr_reg)
                            begin
                                ram_waddr = tcpq_pkg::ring_dec(head_reg);
                            end
                            else
                            begin
                                ram_waddr = tcpq_pkg::ring_add(head_reg,
                                                count_reg[tcpq_pkg::IDX_W-1:0]);
                            end
                        end
                        tcpq_pkg::OP_REMOVE, tcpq_pkg::OP_SEARCH:
                        begin
                            ram_re = !is_empty;
                        end
                        default:
                        begin
                            ram_re = 1'b0;
                        end
                    endcase
                end
            end
            tcpq_pkg::ST_SEARCH:
            begin
                ram_re    = !search_done;
                ram_raddr = tcpq_pkg::ring_add(head_reg, walk_reg[tcpq_pkg::IDX_W-1:0]);
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    assign req.ready = req_ready;

    // Head and occupancy follow the accepted request at once.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (req_fire)
        begin
            if ((op == tcpq_pkg::OP_INSERT) && !is_full)
            begin
                count_next = count_reg + tcpq_pkg::cnt_t'(1);
                if (!is_empty && (req.data_value > thr_reg))
                begin
                    head_next = tcpq_pkg::ring_dec(head_reg);
                end
            end
            else if ((op == tcpq_pkg::OP_REMOVE) && !is_empty)
            begin
                count_next = count_reg - tcpq_pkg::cnt_t'(1);
                head_next  = tcpq_pkg::ring_add(head_reg, tcpq_pkg::idx_t'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcpq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            thr_reg       <= tcpq_pkg::THRESH_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if ((state_reg == tcpq_pkg::ST_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: search key, walk position and the pending result.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            key_reg          <= req.data_value;
            walk_reg         <= tcpq_pkg::cnt_t'(1);
            pend_removed_reg <= '0;
            pend_ok_reg      <= (op == tcpq_pkg::OP_INSERT) && !is_full;
        end
        if (state_reg == tcpq_pkg::ST_READ)
        begin
            pend_ok_reg      <= 1'b1;
            pend_removed_reg <= tcpq_pkg::val_t'(ram_rdata);
        end
        if (state_reg == tcpq_pkg::ST_SEARCH)
        begin
            if (match)
            begin
                pend_ok_reg <= 1'b1;
            end
            if (!search_done)
            begin
                walk_reg <= walk_reg + tcpq_pkg::cnt_t'(1);
            end
        end
        if ((state_reg == tcpq_pkg::ST_DONE) && rsp_free)
        begin
            rsp_ok_reg      <= pend_ok_reg;
            rsp_removed_reg <= pend_removed_reg;
            rsp_count_reg   <= count_reg;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = rsp_ok_reg;
    assign rsp.removed_value = rsp_removed_reg;
    assign rsp.entry_count   = rsp_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tcpq_pkg::DEPTH_CNT)
        else $error("occupancy exceeds queue depth");

    a_full_insert_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (op == tcpq_pkg::OP_INSERT) && is_full)
            |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("insert into a full queue changed the ring");

    a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcpq_pkg::ST_SEARCH) |-> (!is_empty && (walk_reg <= count_reg)))
        else $error("search walk left the occupied window");

    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tcpq_pkg::ST_IDLE) |-> !ram_we)
        else $error("memory written while a request is in progress");

    a_done_before_response: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == tcpq_pkg::ST_DONE))
        else $error("response raised outside the completion state");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the two-class priority queue: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_top;

    import tcpq_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic ok;
        val_t removed_value;
        cnt_t entry_count;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    val_t cfg_wdata;

    tcpq_req_if req_ch ();
    tcpq_rsp_if rsp_ch ();

    two_class_priority_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the queue, kept in step with every accepted request.
    val_t          shadow_store [QUEUE_DEPTH];
    int            shadow_head;
    int            shadow_count;
    val_t          shadow_threshold;
    queue_result_t pending_results [$];
    int            fail_count;
    int            cycle_count;
    bit            idle_on;
    int            stall_left;

    function automatic queue_result_t predict_queue_op(opcode_t op, val_t value);
        queue_result_t res;
        int pos;
        res.ok = 1'b0;
        res.removed_value = '0;
        case (op)
            OP_INSERT:
            begin
                if (shadow_count < QUEUE_DEPTH)
                begin
                    if (shadow_count == 0)
                    begin
                        shadow_store[shadow_head] = value;
                    end
                    else if (value > shadow_threshold)
                    begin
                        shadow_head = (shadow_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        shadow_store[shadow_head] = value;
                    end
                    else
                    begin
                        shadow_store[(shadow_head + shadow_count) % QUEUE_DEPTH] = value;
                    end
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (shadow_count != 0)
                begin
                    res.removed_value = shadow_store[shadow_head];
                    shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            OP_SEARCH:
            begin
                for (pos = 0; pos < shadow_count; pos++)
                begin
                    if (shadow_store[(shadow_head + pos) % QUEUE_DEPTH] == value)
                    begin
                        res.ok = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = cnt_t'(shadow_count);
        return res;
    endfunction

    function automatic val_t pick_value();
        val_t value;
        case ($urandom_range(0, 7))
            0: value = val_t'(24'h800000);
            1: value = val_t'(24'h7FFFFF);
            2, 3: value = shadow_threshold + val_t'($urandom_range(0, 4)) - val_t'(2);
            4:
            begin
                if (shadow_count > 0)
                begin
                    value = shadow_store[(shadow_head + $urandom_range(0, shadow_count - 1))
                                         % QUEUE_DEPTH];
                end
                else
                begin
                    value = val_t'($urandom);
                end
            end
            5: value = val_t'($urandom_range(0, 511)) - val_t'(256);
            default: value = val_t'($urandom);
        endcase
        return value;
    endfunction

    function automatic opcode_t pick_opcode(int insert_pct);
        int roll;
        opcode_t op;
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            op = OP_NOP;
        end
        else if (roll < 20)
        begin
            op = OP_SEARCH;
        end
        else if (roll < 20 + (insert_pct * 80) / 100)
        begin
            op = OP_INSERT;
        end
        else
        begin
            op = OP_REMOVE;
        end
        return op;
    endfunction

    // Entered and left at a falling edge; valid stays high so back-to-back transfers are possible.
    task automatic send_request(opcode_t op, val_t value);
        req_ch.valid      = 1'b1;
        req_ch.opcode     = op;
        req_ch.data_value = value;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        pending_results.push_back(predict_queue_op(op, value));
        @(negedge clk);
    endtask

    task automatic hold_requests(int cycles);
        req_ch.valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_threshold(val_t value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        shadow_threshold = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_directed_basics();
        int k;
        send_request(OP_REMOVE, val_t'(0));
        send_request(OP_SEARCH, val_t'(0));
        send_request(OP_NOP, val_t'(24'h7FFFFF));
        send_request(OP_INSERT, val_t'(15360));
        send_request(OP_INSERT, val_t'(15361));
        send_request(OP_INSERT, val_t'(24'h800000));
        send_request(OP_INSERT, val_t'(24'h7FFFFF));
        send_request(OP_SEARCH, val_t'(15360));
        send_request(OP_SEARCH, val_t'(1));
        send_request(OP_NOP, val_t'(24'h800000));
        for (k = 0; k < 12; k++)
        begin
            if (k % 2 == 0)
            begin
                send_request(OP_INSERT, val_t'(15362 + k));
            end
            else
            begin
                send_request(OP_INSERT, val_t'(-k));
            end
        end
        // The queue is now full: the insert must fail and the search must walk every entry.
        send_request(OP_INSERT, val_t'(100));
        send_request(OP_SEARCH, val_t'(1));
        send_request(OP_REMOVE, val_t'(0));
    endtask

    task automatic test_threshold_extremes();
        write_threshold(val_t'(24'h7FFFFF));
        send_request(OP_INSERT, val_t'(24'h7FFFFF));
        send_request(OP_SEARCH, val_t'(24'h7FFFFF));
        send_request(OP_REMOVE, val_t'(0));
        write_threshold(val_t'(24'h800000));
        send_request(OP_INSERT, val_t'(24'h800000));
        send_request(OP_INSERT, val_t'(24'h800001));
        send_request(OP_REMOVE, val_t'(0));
        write_threshold(val_t'(0));
        send_request(OP_INSERT, val_t'(0));
        send_request(OP_INSERT, val_t'(1));
        send_request(OP_REMOVE, val_t'(0));
    endtask

    task automatic test_random_traffic(int item_total, val_t threshold, bit with_idles);
        int n;
        int insert_pct;
        bit calm;
        write_threshold(threshold);
        idle_on    = with_idles;
        insert_pct = 80;
        calm       = 1'b0;
        for (n = 0; n < item_total; n++)
        begin
            // Alternate fill-heavy and drain-heavy stretches so the ring reaches full and empty.
            if (n % 20 == 0)
            begin
                insert_pct = (insert_pct == 80) ? 25 : 80;
                calm       = ($urandom_range(0, 2) == 0);
            end
            if (idle_on && !calm && $urandom_range(0, 2) == 0)
            begin
                hold_requests($urandom_range(1, 6));
            end
            send_request(pick_opcode(insert_pct), pick_value());
        end
    endtask

    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left     = 0;
            rsp_ch.ready   = 1'b1;
        end
        else if (stall_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp_ch.ready = 1'b0;
            stall_left   = $urandom_range(1, 6) - 1;
        end
        else
        begin
            rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: ok=%0d removed_value=%0d entry_count=%0d",
                       rsp_ch.ok, rsp_ch.removed_value, rsp_ch.entry_count);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.ok !== want.ok)
                begin
                    $error("ok mismatch: expected %0d, got %0d", want.ok, rsp_ch.ok);
                    fail_count++;
                end
                if (rsp_ch.removed_value !== want.removed_value)
                begin
                    $error("removed_value mismatch: expected %0d, got %0d",
                           want.removed_value, rsp_ch.removed_value);
                    fail_count++;
                end
                if (rsp_ch.entry_count !== want.entry_count)
                begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           want.entry_count, rsp_ch.entry_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("two_class_priority_queue test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_INSERT;
        req_ch.data_value = '0;
        rsp_ch.ready      = 1'b0;
        shadow_head       = 0;
        shadow_count      = 0;
        shadow_threshold  = THRESH_RESET;
        fail_count        = 0;
        cycle_count       = 0;
        idle_on           = 1'b1;
        stall_left        = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_basics();
        test_threshold_extremes();
        test_random_traffic(80, THRESH_RESET, 1'b1);
        test_random_traffic(80, val_t'(0), 1'b1);
        test_random_traffic(80, val_t'($urandom), 1'b1);
        test_random_traffic(70, val_t'($urandom_range(0, 2047)) - val_t'(1024), 1'b1);
        // Final stretch runs with no idling on either side.
        test_random_traffic(80, val_t'($urandom), 1'b0);

        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("two_class_priority_queue test passed");
        end
        else
        begin
            $display("two_class_priority_queue test failed");
        end
        $finish;
    end

endmodule
